/* design/button_sum_seven_segment_display_defines.svh */
// Assertion macros shared by the button sum display design.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BUTTON_SUM_SEVEN_SEGMENT_DISPLAY_DEFINES_SVH
`define BUTTON_SUM_SEVEN_SEGMENT_DISPLAY_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define BSSD_ASSERT_NOW(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("bssd assertion failed");

// Next-cycle implication, checked outside of reset.
`define BSSD_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("bssd assertion failed");

`endif

/* design/bssd_pkg.sv */
// Shared types and constants for the button sum seven-segment display.
// No dependencies; every design module refers to it by scoped names.
package bssd_pkg;

	localparam int TOTAL_W = 14;
	localparam int POS_W   = 3;
	localparam int HIST_W  = 13;

	localparam logic [HIST_W-1:0]  HIST_FIRE   = 13'h1000;
	localparam logic [TOTAL_W-1:0] MAX_SHOWN   = 14'd9999;
	localparam logic [TOTAL_W-1:0] LIMIT_RESET = 14'd1023;
	localparam logic [7:0]         BLANK_CODE  = 8'hFF;

	// Display positions.
	localparam logic [POS_W-1:0] POS_ONES      = 3'd0;
	localparam logic [POS_W-1:0] POS_TENS      = 3'd1;
	localparam logic [POS_W-1:0] POS_COLON     = 3'd2;
	localparam logic [POS_W-1:0] POS_HUNDREDS  = 3'd3;
	localparam logic [POS_W-1:0] POS_THOUSANDS = 3'd4;
	localparam logic [POS_W-1:0] POS_LAST      = POS_THOUSANDS;

	// Reciprocals scaled by 2^23 for dividing a 14-bit value by 10, 100 and 1000.
	localparam int RECIP_W = 20;
	localparam int RECIP_SHIFT = 23;
	localparam logic [RECIP_W-1:0] RECIP_10   = 20'd838861;
	localparam logic [RECIP_W-1:0] RECIP_100  = 20'd83887;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 20'd8389;

	// Reciprocal of ten scaled by 2^19, exact for any 16-bit value.
	localparam logic [15:0] RECIP_DIGIT = 16'd52429;
	localparam int RECIP_DIGIT_SHIFT = 19;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [POS_W-1:0]   pos;
	} disp_item_t;

	function automatic logic [7:0] seg_for_digit(input logic [3:0] d);
		logic [7:0] code;
		case (d)
			4'd0: code = 8'b11000000;
			4'd1: code = 8'b11111001;
			4'd2: code = 8'b10100100;
			4'd3: code = 8'b10110000;
			4'd4: code = 8'b10011001;
			4'd5: code = 8'b10010010;
			4'd6: code = 8'b10000010;
			4'd7: code = 8'b11111000;
			4'd8: code = 8'b10000000;
			4'd9: code = 8'b10010000;
			default: code = BLANK_CODE;
		endcase
		return code;
	endfunction

endpackage

/* design/bssd_debounce.sv */
// Per-button shift-register debouncers.
// Uses bssd_pkg for the history width and the firing pattern.
module bssd_debounce #(
	parameter int BUTTON_COUNT = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_en,
	input  logic [BUTTON_COUNT-1:0] levels,
	output logic [BUTTON_COUNT-1:0] fire
);

	logic [bssd_pkg::HIST_W-1:0] hist_q   [BUTTON_COUNT];
	logic [bssd_pkg::HIST_W-1:0] hist_nxt [BUTTON_COUNT];

	// A button fires when one released sample is followed by twelve pressed ones.
	always_comb begin
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			hist_nxt[i] = {hist_q[i][bssd_pkg::HIST_W-2:0], levels[i]};
			fire[i]     = (hist_nxt[i] == bssd_pkg::HIST_FIRE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				hist_q[i] <= '0;
			end
		end else if (sample_en) begin
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				hist_q[i] <= hist_nxt[i];
			end
		end
	end

endmodule

/* design/bssd_accum.sv */
// Running total, wrap limit register and display position counter.
// Uses bssd_pkg for widths, limits, positions and the display item type.
module bssd_accum #(
	parameter int BUTTON_COUNT = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step_en,
	input  logic [BUTTON_COUNT-1:0]          fire,
	input  logic                             cfg_write_en,
	input  logic [bssd_pkg::TOTAL_W-1:0]     cfg_write_data,
	output bssd_pkg::disp_item_t             item
);

	logic [bssd_pkg::TOTAL_W-1:0] total_q;
	logic [bssd_pkg::TOTAL_W-1:0] limit_q;
	logic [bssd_pkg::POS_W-1:0]   pos_q;
	logic [bssd_pkg::TOTAL_W-1:0] limit_eff;
	logic [bssd_pkg::TOTAL_W-1:0] total_sum;
	logic [bssd_pkg::TOTAL_W-1:0] total_nxt;
	logic [bssd_pkg::POS_W-1:0]   pos_cur;
	logic [bssd_pkg::POS_W-1:0]   pos_nxt;
	bssd_pkg::disp_item_t         item_s2;

	// Fire bit i is worth 2^i, so the fire vector itself is the increment.
	always_comb begin
		limit_eff = (limit_q > bssd_pkg::MAX_SHOWN) ? bssd_pkg::MAX_SHOWN : limit_q;
		total_sum = total_q + bssd_pkg::TOTAL_W'(fire);
		total_nxt = (total_sum > limit_eff) ? '0 : total_sum;
		pos_cur   = (pos_q > bssd_pkg::POS_LAST) ? bssd_pkg::POS_ONES : pos_q;
		pos_nxt   = (pos_cur == bssd_pkg::POS_LAST) ? bssd_pkg::POS_ONES
		                                            : pos_cur + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			limit_q <= bssd_pkg::LIMIT_RESET;
			pos_q   <= bssd_pkg::POS_ONES;
		end else begin
			if (cfg_write_en) begin
				limit_q <= cfg_write_data;
			end
			if (step_en) begin
				total_q <= total_nxt;
				pos_q   <= pos_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			item_s2.total <= total_nxt;
			item_s2.pos   <= pos_cur;
		end
	end

	assign item = item_s2;

endmodule

/* design/bssd_decode.sv */
// Two-stage digit decoder: selects the decimal digit for the driven position
// and maps it to an active-low segment code. Uses bssd_pkg.
module bssd_decode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bssd_pkg::disp_item_t         item_in,
	input  logic                         item_valid,
	output logic                         item_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   segment_code,
	output logic [bssd_pkg::POS_W-1:0]   digit_select,
	output logic [bssd_pkg::TOTAL_W-1:0] total_value
);

	localparam int PROD_W  = bssd_pkg::TOTAL_W + bssd_pkg::RECIP_W;
	localparam int DPROD_W = bssd_pkg::TOTAL_W + 16;

	logic                         valid_s3;
	logic                         valid_s4;
	logic                         ready_s3;
	logic                         ready_s4;

	logic [bssd_pkg::RECIP_W-1:0] recip;
	logic [PROD_W-1:0]            quot_prod;
	logic [bssd_pkg::TOTAL_W-1:0] quot;
	logic                         blank;

	logic [bssd_pkg::TOTAL_W-1:0] quot_s3;
	logic                         blank_s3;
	bssd_pkg::disp_item_t         item_s3;

	logic [DPROD_W-1:0]           tens_prod;
	logic [bssd_pkg::TOTAL_W-1:0] tens;
	logic [3:0]                   digit;

	logic [7:0]                   seg_s4;
	bssd_pkg::disp_item_t         item_s4;

	assign ready_s4   = !valid_s4 || out_ready;
	assign ready_s3   = !valid_s3 || ready_s4;
	assign item_ready = ready_s3;

	// Stage 3: scale the total down so the wanted digit is the lowest one.
	always_comb begin
		recip = bssd_pkg::RECIP_10;
		blank = 1'b0;
		case (item_in.pos)
			bssd_pkg::POS_ONES: begin
				recip = bssd_pkg::RECIP_10;
				blank = 1'b0;
			end
			bssd_pkg::POS_TENS: begin
				recip = bssd_pkg::RECIP_10;
				blank = (item_in.total < 14'd10);
			end
			bssd_pkg::POS_HUNDREDS: begin
				recip = bssd_pkg::RECIP_100;
				blank = (item_in.total < 14'd100);
			end
			bssd_pkg::POS_THOUSANDS: begin
				recip = bssd_pkg::RECIP_1000;
				blank = (item_in.total < 14'd1000);
			end
			default: begin
				recip = bssd_pkg::RECIP_10;
				blank = 1'b1;
			end
		endcase
		quot_prod = PROD_W'(item_in.total) * PROD_W'(recip);
		quot = (item_in.pos == bssd_pkg::POS_ONES)
		       ? item_in.total
		       : bssd_pkg::TOTAL_W'(quot_prod >> bssd_pkg::RECIP_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (item_valid && ready_s3) begin
			quot_s3  <= quot;
			blank_s3 <= blank;
			item_s3  <= item_in;
		end
	end

	// Stage 4: the remainder by ten is the digit to show.
	always_comb begin
		tens_prod = DPROD_W'(quot_s3) * DPROD_W'(bssd_pkg::RECIP_DIGIT);
		tens      = bssd_pkg::TOTAL_W'(tens_prod >> bssd_pkg::RECIP_DIGIT_SHIFT);
		digit     = 4'(quot_s3 - bssd_pkg::TOTAL_W'(tens * 14'd10));
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s4) begin
			seg_s4  <= blank_s3 ? bssd_pkg::BLANK_CODE : bssd_pkg::seg_for_digit(digit);
			item_s4 <= item_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= item_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	assign out_valid    = valid_s4;
	assign segment_code = seg_s4;
	assign digit_select = item_s4.pos;
	assign total_value  = item_s4.total;

endmodule

/* design/button_sum_seven_segment_display.sv */
// Button sum display: debounced button presses accumulate into a total that
// is shown one seven-segment position per transfer. One item is taken every
// cycle, and the input stalls only when all four stages hold results the
// consumer has not taken. Reset clears the debounce histories, the total,
// the position counter and all stage valids, and loads the wrap limit with
// 1023.
`include "button_sum_seven_segment_display_defines.svh"

module button_sum_seven_segment_display #(
	parameter int BUTTON_COUNT = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   button_levels,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   segment_code,
	output logic [bssd_pkg::POS_W-1:0]   digit_select,
	output logic [bssd_pkg::TOTAL_W-1:0] total_value,
	input  logic                         cfg_write_en,
	input  logic [bssd_pkg::TOTAL_W-1:0] cfg_write_data
);

	logic                    valid_s1;
	logic                    valid_s2;
	logic [BUTTON_COUNT-1:0] levels_s1;
	logic                    ready_s2;
	logic                    dec_ready;
	logic                    step;
	logic [BUTTON_COUNT-1:0] fire;
	bssd_pkg::disp_item_t    item_s2;

	assign ready_s2 = !valid_s2 || dec_ready;
	assign in_ready = !valid_s1 || ready_s2;
	// The debouncers and the total advance exactly when an item leaves stage 1.
	assign step     = valid_s1 && ready_s2;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			levels_s1 <= button_levels[BUTTON_COUNT-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	bssd_debounce #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_debounce (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_en (step),
		.levels    (levels_s1),
		.fire      (fire)
	);

	bssd_accum #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (step),
		.fire           (fire),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.item           (item_s2)
	);

	bssd_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_in      (item_s2),
		.item_valid   (valid_s2),
		.item_ready   (dec_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.segment_code (segment_code),
		.digit_select (digit_select),
		.total_value  (total_value)
	);

	// The wrapped total always fits in four decimal digits.
	`BSSD_ASSERT_NOW(a_total_in_range, out_valid, total_value <= bssd_pkg::MAX_SHOWN)
	// The colon position is never lit.
	`BSSD_ASSERT_NOW(a_colon_blank, out_valid && digit_select == bssd_pkg::POS_COLON, segment_code == bssd_pkg::BLANK_CODE)
	// Input can only stall when a finished result is waiting at the output.
	`BSSD_ASSERT_NOW(a_stall_needs_full, !in_ready, out_valid && !out_ready)
	// A stage-1 item with room ahead moves on in the next cycle.
	`BSSD_ASSERT_NEXT(a_s1_moves, valid_s1 && ready_s2, valid_s2)

endmodule

/* dv/button_sum_display_checker.sv */
// Checker for the button sum seven-segment display: watches the input, result
// and register ports, predicts every shown position and compares each field.
// Depends on bssd_pkg for field widths, position codes and reset constants.
module button_sum_display_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [7:0]                   button_levels,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [7:0]                   segment_code,
	input  logic [bssd_pkg::POS_W-1:0]   digit_select,
	input  logic [bssd_pkg::TOTAL_W-1:0] total_value,
	input  logic                         cfg_write_en,
	input  logic [bssd_pkg::TOTAL_W-1:0] cfg_write_data,
	output int                           mismatch_count,
	output int                           awaited_count
);

	localparam int BUTTONS = 8;

	typedef struct packed {
		logic [7:0]                   segs;
		logic [bssd_pkg::POS_W-1:0]   pos;
		logic [bssd_pkg::TOTAL_W-1:0] total;
	} shown_t;

	logic [bssd_pkg::HIST_W-1:0]  press_hist [BUTTONS];
	logic [bssd_pkg::TOTAL_W-1:0] tally;
	logic [bssd_pkg::POS_W-1:0]   place;
	logic [bssd_pkg::TOTAL_W-1:0] wrap_limit;
	shown_t                       expected_shown [$];

	function automatic logic [7:0] glyph_for(input int value,
			input logic [bssd_pkg::POS_W-1:0] pos);
		int scale;
		logic [7:0] code;
		code = bssd_pkg::BLANK_CODE;
		case (pos)
			bssd_pkg::POS_ONES: scale = 1;
			bssd_pkg::POS_TENS: scale = 10;
			bssd_pkg::POS_HUNDREDS: scale = 100;
			bssd_pkg::POS_THOUSANDS: scale = 1000;
			default: scale = 0;
		endcase
		// Leading zeros stay dark, but a zero total still lights the ones digit.
		if (scale != 0 && (pos == bssd_pkg::POS_ONES || value >= scale)) begin
			case ((value / scale) % 10)
				0: code = 8'hC0;
				1: code = 8'hF9;
				2: code = 8'hA4;
				3: code = 8'hB0;
				4: code = 8'h99;
				5: code = 8'h92;
				6: code = 8'h82;
				7: code = 8'hF8;
				8: code = 8'h80;
				9: code = 8'h90;
				default: code = bssd_pkg::BLANK_CODE;
			endcase
		end
		return code;
	endfunction

	task automatic predict_tick(input logic [7:0] levels);
		int sum;
		int cap;
		logic [bssd_pkg::POS_W-1:0] p;
		shown_t s;
		sum = tally;
		cap = (wrap_limit > bssd_pkg::MAX_SHOWN) ? bssd_pkg::MAX_SHOWN : wrap_limit;
		// All presses of the tick are added before the wrap is applied once.
		for (int i = 0; i < BUTTONS; i++) begin
			press_hist[i] = {press_hist[i][bssd_pkg::HIST_W-2:0], levels[i]};
			if (press_hist[i] == bssd_pkg::HIST_FIRE)
				sum += 1 << i;
		end
		if (sum > cap)
			sum = 0;
		tally = sum[bssd_pkg::TOTAL_W-1:0];
		p = (place > bssd_pkg::POS_LAST) ? bssd_pkg::POS_ONES : place;
		s.segs = glyph_for(sum, p);
		s.pos = p;
		s.total = tally;
		expected_shown.push_back(s);
		place = (p == bssd_pkg::POS_LAST) ? bssd_pkg::POS_ONES : p + 1'b1;
	endtask

	task automatic check_shown();
		shown_t want;
		if (expected_shown.size() == 0) begin
			$error("result transfer with nothing expected: segment_code %h digit_select %0d total_value %0d",
				segment_code, digit_select, total_value);
			mismatch_count++;
		end else begin
			want = expected_shown.pop_front();
			if (segment_code !== want.segs) begin
				$error("segment_code: expected %h, actual %h", want.segs, segment_code);
				mismatch_count++;
			end
			if (digit_select !== want.pos) begin
				$error("digit_select: expected %0d, actual %0d", want.pos, digit_select);
				mismatch_count++;
			end
			if (total_value !== want.total) begin
				$error("total_value: expected %0d, actual %0d", want.total, total_value);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (press_hist[i])
				press_hist[i] = '0;
			tally = '0;
			place = bssd_pkg::POS_ONES;
			wrap_limit = bssd_pkg::LIMIT_RESET;
			expected_shown.delete();
			awaited_count = 0;
			mismatch_count = 0;
		end else begin
			if (out_valid && out_ready)
				check_shown();
			if (cfg_write_en)
				wrap_limit = cfg_write_data;
			if (in_valid && in_ready)
				predict_tick(button_levels);
			awaited_count = expected_shown.size();
		end
	end

endmodule

/* dv/tb_button_sum_seven_segment_display.sv */
// Testbench top for the button sum seven-segment display: drives button
// patterns, random stalls and wrap limit writes, and reports the verdict.
// Depends on bssd_pkg, the display block and button_sum_display_checker.
module tb_button_sum_seven_segment_display;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [7:0]                   button_levels = 8'hFF;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [7:0]                   segment_code;
	logic [bssd_pkg::POS_W-1:0]   digit_select;
	logic [bssd_pkg::TOTAL_W-1:0] total_value;
	logic                         cfg_write_en = 1'b0;
	logic [bssd_pkg::TOTAL_W-1:0] cfg_write_data = '0;
	int                           mismatch_count;
	int                           awaited_count;

	// While steady is set neither side idles.
	bit                           steady = 1'b0;
	logic [7:0]                   held = 8'hFF;
	int                           hold_left [8];

	button_sum_seven_segment_display dut (.*);

	button_sum_display_checker checker_i (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 9);
	end

	initial begin
		#400000;
		$display("** button_sum_seven_segment_display: FAILED **");
		$finish;
	end

	// Human-like presses: a short release, then usually a hold long enough to
	// register, sometimes a bounce that is too short. In gang mode all buttons
	// move together with minimal gaps, which drives the total up fast.
	function automatic logic [7:0] next_levels(input bit gang);
		int span;
		for (int i = 0; i < (gang ? 1 : 8); i++) begin
			if (hold_left[i] == 0) begin
				held[i] = ~held[i];
				if (held[i])
					span = gang ? 1 : $urandom_range(1, 8);
				else if (gang)
					span = $urandom_range(12, 13);
				else if ($urandom_range(0, 3) == 0)
					span = $urandom_range(1, 11);
				else
					span = $urandom_range(12, 24);
				hold_left[i] = span;
			end
			hold_left[i]--;
		end
		if ($urandom_range(0, 99) < (gang ? 3 : 10))
			return 8'($urandom_range(0, 255));
		return gang ? {8{held[0]}} : held;
	endfunction

	// Returns at the clock edge that completes the transfer.
	task automatic send_levels(input logic [7:0] levels);
		while (!steady && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button_levels <= levels;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (awaited_count != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_wrap_limit(input logic [bssd_pkg::TOTAL_W-1:0] limit);
		drain_results();
		cfg_write_en <= 1'b1;
		cfg_write_data <= limit;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// All eight buttons register on the same tick, then a hold one
		// sample too short to count.
		send_levels(8'hFF);
		repeat (12) send_levels(8'h00);
		send_levels(8'hFF);
		repeat (11) send_levels(8'h00);
		send_levels(8'hFF);

		write_wrap_limit(bssd_pkg::LIMIT_RESET);
		repeat (120) send_levels(next_levels(1'b0));
		drain_results();
		repeat (120) send_levels(next_levels(1'b0));

		write_wrap_limit('0);
		repeat (80) send_levels(next_levels(1'b0));

		steady <= 1'b1;
		write_wrap_limit({bssd_pkg::TOTAL_W{1'b1}});
		repeat (320) send_levels(next_levels(1'b1));

		steady <= 1'b0;
		write_wrap_limit(bssd_pkg::MAX_SHOWN);
		repeat (280) send_levels(next_levels(1'b1));

		write_wrap_limit(bssd_pkg::TOTAL_W'($urandom_range(1, 400)));
		repeat (100) send_levels(next_levels(1'b0));

		drain_results();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("** button_sum_seven_segment_display: PASSED **");
		else
			$display("** button_sum_seven_segment_display: FAILED **");
		$finish;
	end

endmodule
